// File: rtl/bba_pkg.sv
package bba_pkg;

  localparam int unsigned MAX_ORDER_DEF = 16;
  localparam int unsigned MIN_ORDER_DEF = 3;

  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned ORDO_W  = 5;
  localparam int unsigned ORD_W   = 6;
  localparam int unsigned STAT_W  = 2;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADFREE = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;

  typedef enum logic [1:0] {
    NS_UNUSED = 2'd0,
    NS_AVAIL  = 2'd1,
    NS_ALLOC  = 2'd2,
    NS_SPLIT  = 2'd3
  } node_e;

  typedef enum logic [1:0] {
    WR_IDX    = 2'd0,
    WR_RIGHT  = 2'd1,
    WR_PARENT = 2'd2,
    WR_ROOT   = 2'd3
  } wr_sel_e;

  typedef enum logic [2:0] {
    IDX_HOLD    = 3'd0,
    IDX_LEFT    = 3'd1,
    IDX_DESCEND = 3'd2,
    IDX_UP      = 3'd3,
    IDX_NEXT    = 3'd4
  } idx_op_e;

  typedef enum logic [1:0] {
    RES_GRANT   = 2'd0,
    RES_OK      = 2'd1,
    RES_NOFIT   = 2'd2,
    RES_BADFREE = 2'd3
  } res_e;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    logic    rd_sib;
    logic    wr_en;
    wr_sel_e wr_sel;
    node_e   wr_val;
    idx_op_e idx_op;
    logic    res_en;
    res_e    res_kind;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic  func;
    logic  req_big;
    logic  addr_big;
    node_e node;
    logic  ord_gt_req;
    logic  ord_gt_min;
    logic  idx_root;
    logic  idx_odd;
    logic  addr_hit;
    logic  out_free;
  } stat_t;

endpackage

// File: rtl/bba_datapath.sv
module bba_datapath import bba_pkg::*; #(
  parameter int unsigned MAX_ORDER = MAX_ORDER_DEF,
  parameter int unsigned MIN_ORDER = MIN_ORDER_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic              in_func_i,
  input  logic [SIZE_W-1:0] in_size_i,
  input  logic [ADDR_W-1:0] in_addr_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [STAT_W-1:0] out_status_o,
  output logic [ADDR_W-1:0] out_addr_o,
  output logic [ORDO_W-1:0] out_order_o
);

  localparam int unsigned LEVELS = MAX_ORDER - MIN_ORDER + 1;
  localparam int unsigned NODES  = 1 << LEVELS;
  localparam int unsigned IW     = LEVELS;
  localparam int unsigned AW     = ((MAX_ORDER > ADDR_W) ? MAX_ORDER : ADDR_W) + 1;

  // Smallest order at or above the minimum whose block holds the size.
  function automatic logic [ORD_W-1:0] f_req(input logic [SIZE_W-1:0] sz);
    logic [ORD_W-1:0] r;
    r = ORD_W'(SIZE_W);
    for (int k = SIZE_W; k >= int'(MIN_ORDER); k--) begin
      if (((SIZE_W+1)'(1) << k) >= {1'b0, sz}) begin
        r = ORD_W'(k);
      end
    end
    return r;
  endfunction

  node_e mem [NODES];
  node_e rdata_q;

  logic              func_q;
  logic [ORD_W-1:0]  req_q;
  logic [AW-1:0]     addr_q;
  logic [IW-1:0]     idx_q, idx_d;
  logic [ORD_W-1:0]  ord_q, ord_d;
  logic [AW-1:0]     base_q, base_d;

  logic [IW-1:0]     waddr, raddr;
  logic [AW-1:0]     half;
  logic [IW-1:0]     idx_off;
  logic [IW-1:0]     lvl;
  logic [AW-1:0]     grant_base;

  logic              res_valid_unused;
  logic [STAT_W-1:0] res_status_q;
  logic [ADDR_W-1:0] res_addr_q;
  logic [ORDO_W-1:0] res_order_q;
  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [ORDO_W-1:0] out_order_q;

  assign res_valid_unused = 1'b0;

  always_comb begin
    case (cmd_i.wr_sel)
      WR_IDX:    waddr = idx_q;
      WR_RIGHT:  waddr = {idx_q[IW-2:0], 1'b1};
      WR_PARENT: waddr = idx_q >> 1;
      WR_ROOT:   waddr = IW'(1);
      default:   waddr = idx_q;
    endcase
  end

  assign raddr = cmd_i.rd_sib ? (idx_q ^ IW'(1)) : idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[waddr] <= cmd_i.wr_val;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  assign half = (ord_q == '0) ? '0 : (AW'(1) << (ord_q - ORD_W'(1)));

  always_comb begin
    idx_d  = idx_q;
    ord_d  = ord_q;
    base_d = base_q;
    case (cmd_i.idx_op)
      IDX_HOLD: begin
      end
      IDX_LEFT: begin
        idx_d = {idx_q[IW-2:0], 1'b0};
        ord_d = ord_q - ORD_W'(1);
      end
      IDX_DESCEND: begin
        ord_d = ord_q - ORD_W'(1);
        if (addr_q >= base_q + half) begin
          base_d = base_q + half;
          idx_d  = {idx_q[IW-2:0], 1'b1};
        end else begin
          idx_d  = {idx_q[IW-2:0], 1'b0};
        end
      end
      IDX_UP: begin
        idx_d = idx_q >> 1;
        ord_d = ord_q + ORD_W'(1);
      end
      IDX_NEXT: begin
        idx_d = idx_q + IW'(1);
      end
      default: begin
      end
    endcase
    if (cmd_i.load) begin
      idx_d  = IW'(1);
      ord_d  = ORD_W'(MAX_ORDER);
      base_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_func_i;
      req_q  <= f_req(in_size_i);
      addr_q <= AW'(in_addr_i);
    end
    idx_q  <= idx_d;
    ord_q  <= ord_d;
    base_q <= base_d;
  end

  // Offset of a tree node: its position within its level times its size.
  assign lvl        = IW'(ORD_W'(MAX_ORDER) - ord_q);
  assign idx_off    = idx_q & ~(IW'(1) << lvl);
  assign grant_base = AW'(idx_off) << ord_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_en) begin
      case (cmd_i.res_kind)
        RES_GRANT: begin
          res_status_q <= ST_DONE;
          res_addr_q   <= grant_base[ADDR_W-1:0];
          res_order_q  <= ord_q[ORDO_W-1:0];
        end
        RES_OK: begin
          res_status_q <= ST_DONE;
          res_addr_q   <= '0;
          res_order_q  <= '0;
        end
        RES_NOFIT: begin
          res_status_q <= ST_NOFIT;
          res_addr_q   <= '0;
          res_order_q  <= '0;
        end
        default: begin
          res_status_q <= ST_BADFREE;
          res_addr_q   <= '0;
          res_order_q  <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= res_valid_unused;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_order_q  <= res_order_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_addr_o   = out_addr_q;
  assign out_order_o  = out_order_q;

  assign stat_o.func       = func_q;
  assign stat_o.req_big    = req_q > ORD_W'(MAX_ORDER);
  assign stat_o.addr_big   = addr_q >= (AW'(1) << MAX_ORDER);
  assign stat_o.node       = rdata_q;
  assign stat_o.ord_gt_req = ord_q > req_q;
  assign stat_o.ord_gt_min = ord_q > ORD_W'(MIN_ORDER);
  assign stat_o.idx_root   = idx_q == IW'(1);
  assign stat_o.idx_odd    = idx_q[0];
  assign stat_o.addr_hit   = addr_q == base_q;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// File: rtl/bba_ctrl.sv
module bba_ctrl import bba_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [13:0] {
    S_INIT   = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_ACHK   = 14'b00000000000100,
    S_AREAD  = 14'b00000000001000,
    S_AEVAL  = 14'b00000000010000,
    S_AUP    = 14'b00000000100000,
    S_SPLIT  = 14'b00000001000000,
    S_SPLIT2 = 14'b00000010000000,
    S_FCHK   = 14'b00000100000000,
    S_FREAD  = 14'b00001000000000,
    S_FEVAL  = 14'b00010000000000,
    S_MRD    = 14'b00100000000000,
    S_MEVAL  = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_ROOT;
        cmd_o.wr_val = NS_AVAIL;
        state_d      = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_ACHK;
        end
      end
      S_ACHK: begin
        if (stat_i.func != FUNC_ALLOC) begin
          state_d = S_FCHK;
        end else if (stat_i.req_big) begin
          cmd_o.res_en   = 1'b1;
          cmd_o.res_kind = RES_NOFIT;
          state_d        = S_DONE;
        end else begin
          state_d = S_AREAD;
        end
      end
      S_AREAD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_AEVAL;
      end
      S_AEVAL: begin
        if (stat_i.node == NS_AVAIL) begin
          state_d = S_SPLIT;
        end else if (stat_i.node == NS_SPLIT && stat_i.ord_gt_req && stat_i.ord_gt_min) begin
          cmd_o.idx_op = IDX_LEFT;
          state_d      = S_AREAD;
        end else begin
          state_d = S_AUP;
        end
      end
      S_AUP: begin
        if (stat_i.idx_root) begin
          cmd_o.res_en   = 1'b1;
          cmd_o.res_kind = RES_NOFIT;
          state_d        = S_DONE;
        end else if (stat_i.idx_odd) begin
          cmd_o.idx_op = IDX_UP;
        end else begin
          cmd_o.idx_op = IDX_NEXT;
          state_d      = S_AREAD;
        end
      end
      S_SPLIT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_IDX;
        if (stat_i.ord_gt_req && stat_i.ord_gt_min) begin
          cmd_o.wr_val = NS_SPLIT;
          state_d      = S_SPLIT2;
        end else begin
          cmd_o.wr_val   = NS_ALLOC;
          cmd_o.res_en   = 1'b1;
          cmd_o.res_kind = RES_GRANT;
          state_d        = S_DONE;
        end
      end
      S_SPLIT2: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_RIGHT;
        cmd_o.wr_val = NS_AVAIL;
        cmd_o.idx_op = IDX_LEFT;
        state_d      = S_SPLIT;
      end
      S_FCHK: begin
        if (stat_i.addr_big) begin
          cmd_o.res_en   = 1'b1;
          cmd_o.res_kind = RES_BADFREE;
          state_d        = S_DONE;
        end else begin
          state_d = S_FREAD;
        end
      end
      S_FREAD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_FEVAL;
      end
      S_FEVAL: begin
        if (stat_i.node == NS_ALLOC && stat_i.addr_hit) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_IDX;
          cmd_o.wr_val = NS_AVAIL;
          state_d      = S_MRD;
        end else if (stat_i.node == NS_SPLIT && stat_i.ord_gt_min) begin
          cmd_o.idx_op = IDX_DESCEND;
          state_d      = S_FREAD;
        end else begin
          cmd_o.res_en   = 1'b1;
          cmd_o.res_kind = RES_BADFREE;
          state_d        = S_DONE;
        end
      end
      S_MRD: begin
        if (stat_i.idx_root) begin
          cmd_o.res_en   = 1'b1;
          cmd_o.res_kind = RES_OK;
          state_d        = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sib = 1'b1;
          state_d      = S_MEVAL;
        end
      end
      S_MEVAL: begin
        if (stat_i.node == NS_AVAIL) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_PARENT;
          cmd_o.wr_val = NS_AVAIL;
          cmd_o.idx_op = IDX_UP;
          state_d      = S_MRD;
        end else begin
          cmd_o.res_en   = 1'b1;
          cmd_o.res_kind = RES_OK;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/buddy_block_allocator.sv
// Operation: allocate checks the size, reads nodes in a first-fit walk with backtrack steps,
// then splits one level at a time (the walk may read every node at or above the requested
// order); free checks the address, reads nodes on the way down, then merges level by level.
// Throughput: one request at a time; the next transaction is taken once the result has moved
// to the output register, and later while an earlier result still waits on the output.
// Reset: asynchronous, active low. After reset the init state writes the root entry as free;
// no other entry is cleared, because only children of split nodes, always written, are read.
module buddy_block_allocator import bba_pkg::*; #(
  parameter int unsigned MAX_ORDER = MAX_ORDER_DEF,
  parameter int unsigned MIN_ORDER = MIN_ORDER_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: alloc_size [31:0], block_address [47:32].
  input  logic [47:0] s_axis_tdata,
  // tuser: func [0] (0 allocate, 1 free).
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: granted_address [15:0], granted_order [20:16], zero pad [23:21].
  output logic [23:0] m_axis_tdata,
  // tuser: status [1:0].
  output logic [1:0]  m_axis_tuser
);

  // The controller sequences the tree walks; the datapath holds the node-state memory,
  // the walk registers and the output register, so a result can wait while the next
  // transaction is taken in.
  cmd_t              cmd;
  stat_t             stat;
  logic [ADDR_W-1:0] out_addr;
  logic [ORDO_W-1:0] out_order;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bba_datapath #(
    .MAX_ORDER (MAX_ORDER),
    .MIN_ORDER (MIN_ORDER)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_func_i    (s_axis_tuser),
    .in_size_i    (s_axis_tdata[31:0]),
    .in_addr_i    (s_axis_tdata[47:32]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_addr_o   (out_addr),
    .out_order_o  (out_order)
  );

  assign m_axis_tdata = {3'b000, out_order, out_addr};

  // A result never carries the unused status code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= ST_BADFREE)
    else $error("invalid status code");

  // A failed request never reports a granted block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ST_DONE) |-> m_axis_tdata == 24'd0)
    else $error("failed request carries grant fields");

  // After a transaction is accepted the block is busy with it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second transaction accepted while busy");

endmodule
